FILE: design/assert_macros.svh
// Assertion helper macros used by the checker file sacta_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/sacta_pkg.sv
// ----------------------------------------------------------------------------
// sacta_pkg
// Shared command codes, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sacta_pkg;

    localparam int ADDR_W = 48;
    localparam int DATA_W = 64;
    localparam int WAY_W  = 4;

    // Command codes.
    localparam logic [1:0] CMD_LOOKUP     = 2'd0;
    localparam logic [1:0] CMD_FILL       = 2'd1;
    localparam logic [1:0] CMD_INVALIDATE = 2'd2;

    // Access kinds of interest.
    localparam logic [2:0] KIND_WRITE = 3'd3;

    // Request word as held by the datapath.
    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [2:0]        access_kind;
        logic              own_prefetch;
        logic [DATA_W-1:0] fill_data;
        logic [WAY_W-1:0]  victim_way;
        logic              writeback_ready;
    } req_t;

    // Result word.
    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way_index;
        logic              pf_useful;
        logic [DATA_W-1:0] read_data;
        logic              accepted;
        logic              writeback_valid;
        logic [ADDR_W-1:0] writeback_address;
        logic [DATA_W-1:0] writeback_data;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;   // capture request, start set read
        logic clear_step; // write one valid row during the clearing pass
        logic resolve;    // compare ways, update state, build result
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/sacta_datapath.sv
// ----------------------------------------------------------------------------
// sacta_datapath
// Set arrays, way compare, victim choice, state update and result build.
// ----------------------------------------------------------------------------
`default_nettype none

module sacta_datapath #(
    parameter int SETS             = 64,
    parameter int WAYS             = 8,
    parameter int LINE_OFFSET_BITS = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sacta_pkg::dp_cmd_t cmd,
    output sacta_pkg::dp_sts_t    sts,
    input  wire sacta_pkg::req_t  req,
    output sacta_pkg::rsp_t       rsp
);
    import sacta_pkg::*;

    // Set index uses floor(log2(SETS)) bits; at least one bit of storage.
    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int ROWS     = 1 << SET_BITS;
    localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = ADDR_W - LINE_OFFSET_BITS;
    localparam int WIDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [WAY_W-1:0] NONE_WAY = WAY_W'(WAYS);

    // Memories: one row per set, all ways side by side.
    logic [WAYS-1:0]       valid_mem   [ROWS];
    logic [WAYS-1:0]       dirty_mem   [ROWS];
    logic [WAYS-1:0]       pf_mem      [ROWS];
    logic [ADDR_W-1:0]     addr_mem    [ROWS][WAYS];
    logic [DATA_W-1:0]     data_mem    [ROWS][WAYS];

    // Registered read rows and request.
    logic [WAYS-1:0]       valid_rd_reg;
    logic [WAYS-1:0]       dirty_rd_reg;
    logic [WAYS-1:0]       pf_rd_reg;
    logic [ADDR_W-1:0]     addr_rd_reg [WAYS];
    logic [DATA_W-1:0]     data_rd_reg [WAYS];
    req_t                  req_reg;
    logic [IDX_W-1:0]      set_reg;
    logic [IDX_W-1:0]      clr_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic [IDX_W-1:0]      set_in;

    // Set index of the incoming request.
    always_comb
    begin
        if (SET_BITS > 0)
            set_in = IDX_W'(req.address >> LINE_OFFSET_BITS);
        else
            set_in = '0;
    end

    assign sts.clear_last = (clr_reg == IDX_W'(ROWS - 1));
    assign rsp = rsp_reg;

    // Clearing pass row counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_step)
            clr_reg <= clr_reg + 1'b1;
    end

    // Way compare and victim choice on the registered row.
    logic [WAYS-1:0]    match;
    logic               found;
    logic [WAY_W-1:0]   mway;
    logic               has_inv;
    logic [WAY_W-1:0]   iway;
    logic [WAY_W-1:0]   fway;
    logic               fbypass;
    logic [TAG_W-1:0]   rtag;
    logic [WIDX_W-1:0]  mway_i;
    logic [WIDX_W-1:0]  fway_i;
    logic               pf_useful_hit;
    logic               victim_dirty;
    logic               fill_store;

    always_comb
    begin
        rtag = req_reg.address[ADDR_W-1:LINE_OFFSET_BITS];
        found = 1'b0;
        mway = NONE_WAY;
        has_inv = 1'b0;
        iway = NONE_WAY;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = valid_rd_reg[w] &&
                       (addr_rd_reg[w][ADDR_W-1:LINE_OFFSET_BITS] == rtag);
            if (match[w]) begin
                found = 1'b1;
                mway = WAY_W'(w);
            end
            if (!valid_rd_reg[w]) begin
                has_inv = 1'b1;
                iway = WAY_W'(w);
            end
        end
        if (has_inv) begin
            fway = iway;
            fbypass = 1'b0;
        end else if (req_reg.victim_way < NONE_WAY) begin
            fway = req_reg.victim_way;
            fbypass = 1'b0;
        end else begin
            fway = NONE_WAY;
            fbypass = 1'b1;
        end
    end

    // Update decisions and the result word for the resolve cycle.
    always_comb
    begin
        mway_i        = mway[WIDX_W-1:0];
        fway_i        = fway[WIDX_W-1:0];
        pf_useful_hit = pf_rd_reg[mway_i] && !req_reg.own_prefetch;
        victim_dirty  = valid_rd_reg[fway_i] && dirty_rd_reg[fway_i];
        fill_store    = !fbypass && (!victim_dirty || req_reg.writeback_ready);
        rsp_next           = '0;
        rsp_next.way_index = NONE_WAY;
        if (req_reg.command == CMD_LOOKUP) begin
            if (found) begin
                rsp_next.hit       = 1'b1;
                rsp_next.way_index = mway;
                rsp_next.pf_useful = pf_useful_hit;
                rsp_next.read_data = data_rd_reg[mway_i];
            end
        end else if (req_reg.command == CMD_FILL) begin
            if (fbypass) begin
                rsp_next.accepted = 1'b1;
            end else begin
                rsp_next.way_index = fway;
                rsp_next.accepted  = fill_store;
                if (fill_store && victim_dirty) begin
                    rsp_next.writeback_valid   = 1'b1;
                    rsp_next.writeback_address = addr_rd_reg[fway_i];
                    rsp_next.writeback_data    = data_rd_reg[fway_i];
                end
            end
        end else if (req_reg.command == CMD_INVALIDATE) begin
            if (found) begin
                rsp_next.hit       = 1'b1;
                rsp_next.way_index = mway;
            end
        end
    end

    // Array update and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            valid_mem[clr_reg] <= '0;
        if (cmd.load_req) begin
            req_reg      <= req;
            set_reg      <= set_in;
            valid_rd_reg <= valid_mem[set_in];
            dirty_rd_reg <= dirty_mem[set_in];
            pf_rd_reg    <= pf_mem[set_in];
            for (int w = 0; w < WAYS; w++) begin
                addr_rd_reg[w] <= addr_mem[set_in][w];
                data_rd_reg[w] <= data_mem[set_in][w];
            end
        end
        if (cmd.resolve) begin
            rsp_reg <= rsp_next;
            unique case (req_reg.command)
                CMD_LOOKUP:
                begin
                    if (found) begin
                        if (req_reg.access_kind == KIND_WRITE)
                            dirty_mem[set_reg][mway_i] <= 1'b1;
                        if (pf_useful_hit)
                            pf_mem[set_reg][mway_i] <= 1'b0;
                    end
                end
                CMD_FILL:
                begin
                    if (fill_store) begin
                        valid_mem[set_reg][fway_i] <= 1'b1;
                        dirty_mem[set_reg][fway_i] <=
                            (req_reg.access_kind == KIND_WRITE);
                        pf_mem[set_reg][fway_i]   <= req_reg.own_prefetch;
                        addr_mem[set_reg][fway_i] <= req_reg.address;
                        data_mem[set_reg][fway_i] <= req_reg.fill_data;
                    end
                end
                CMD_INVALIDATE:
                begin
                    if (found)
                        valid_mem[set_reg][mway_i] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/sacta_ctrl.sv
// ----------------------------------------------------------------------------
// sacta_ctrl
// Sequencer: clearing pass, request capture, resolve, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module sacta_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sacta_pkg::dp_cmd_t cmd,
    input  wire sacta_pkg::dp_sts_t sts
);
    import sacta_pkg::*;

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;
    localparam logic [1:0] ST_OUT     = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd.load_req   = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.resolve    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.load_req = in_valid;
                if (in_valid)
                    state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: design/set_assoc_cache_tag_array_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_unit
// Write-back set-associative tag and data array with lookup, fill, invalidate.
// ----------------------------------------------------------------------------
// Usage: one request word enters on the s_axis channel and one result word
// leaves on the m_axis channel for each request. A request is a lookup, a
// fill or an invalidate of one line. Each request goes through these steps:
// capture with set read, compare and update, then a result held in an
// output register until m_axis_tready; the next request is taken in the
// cycle after the result leaves, so a new request is never taken before
// the result of the last one has left.
// After reset the block runs a clearing pass over the valid bits of all
// 2**floor(log2(SETS)) rows, one set per cycle, with s_axis_tready low.
// When the receiver stalls, the result stays on m_axis_tdata unchanged and
// no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_array_unit #(
    parameter int SETS             = 64,
    parameter int WAYS             = 8,
    parameter int LINE_OFFSET_BITS = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[1:0], address[49:2], access_kind[52:50], own_prefetch[53],
    // fill_data[117:54], victim_way[121:118], writeback_ready[122], zero pad
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit[0], way_index[4:1], pf_useful[5], read_data[69:6],
    // accepted[70], writeback_valid[71], writeback_address[119:72],
    // writeback_data[183:120], zero pad
    output logic [191:0]      m_axis_tdata
);
    import sacta_pkg::*;

    req_t    req;
    rsp_t    rsp;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // Unpack request word.
    assign req.command         = s_axis_tdata[1:0];
    assign req.address         = s_axis_tdata[49:2];
    assign req.access_kind     = s_axis_tdata[52:50];
    assign req.own_prefetch    = s_axis_tdata[53];
    assign req.fill_data       = s_axis_tdata[117:54];
    assign req.victim_way      = s_axis_tdata[121:118];
    assign req.writeback_ready = s_axis_tdata[122];

    // Pack result word.
    assign m_axis_tdata = {8'd0, rsp.writeback_data, rsp.writeback_address,
                           rsp.writeback_valid, rsp.accepted, rsp.read_data,
                           rsp.pf_useful, rsp.way_index, rsp.hit};

    sacta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sacta_datapath #(
        .SETS             (SETS),
        .WAYS             (WAYS),
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

FILE: design/sacta_checker.sv
// ----------------------------------------------------------------------------
// sacta_checker
// Port-level checks of the request/result sequencing of the tag array.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sacta_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [191:0] m_axis_tdata
);
    // A request is never taken while a result waits.
    `CHK_IMPLY(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready, "request taken during result")
    // An accepted request is followed by a result once its resolve step is done.
    `CHK_NEXT(a_latency, clk, rst_n, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid, "result missing")
    // A stalled result keeps its word.
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled word changed")
    // A writeback is only reported on an accepted fill.
    `CHK_IMPLY(a_wb_acc, clk, rst_n, m_axis_tvalid && m_axis_tdata[71], m_axis_tdata[70], "writeback without accept")
endmodule

bind set_assoc_cache_tag_array_unit sacta_checker u_sacta_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/set_assoc_cache_tag_array_checker.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_checker
// Watches both stream channels of the cache tag array, keeps its own copy of
// the tag, state and data store, works out the result word for every accepted
// request word and compares it with the result words leaving the block.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_array_checker #(
    parameter int SETS             = 64,
    parameter int WAYS             = 8,
    parameter int LINE_OFFSET_BITS = 6
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    // command[1:0], address[49:2], access_kind[52:50], own_prefetch[53],
    // fill_data[117:54], victim_way[121:118], writeback_ready[122], zero pad
    input  wire logic [127:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit[0], way_index[4:1], pf_useful[5], read_data[69:6],
    // accepted[70], writeback_valid[71], writeback_address[119:72],
    // writeback_data[183:120], zero pad
    input  wire logic [191:0] m_axis_tdata,
    output int                error_count,
    output int                pending_count,
    output int                hit_count,
    output int                writeback_count,
    output int                refused_count
);
    import sacta_pkg::*;

    // The set index keeps floor(log2(SETS)) bits of the line address.
    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int LINES    = SETS * WAYS;
    localparam logic [WAY_W-1:0] NO_WAY = WAY_W'(WAYS);

    typedef struct {
        logic              hit;
        logic [WAY_W-1:0]  way_index;
        logic              pf_useful;
        logic [DATA_W-1:0] read_data;
        logic              accepted;
        logic              writeback_valid;
        logic [ADDR_W-1:0] writeback_address;
        logic [DATA_W-1:0] writeback_data;
    } result_t;

    // Model copy of the per-line store.
    logic              line_valid  [LINES];
    logic              line_dirty  [LINES];
    logic              line_pf     [LINES];
    logic [ADDR_W-1:0] line_addr   [LINES];
    logic [DATA_W-1:0] line_payload[LINES];

    result_t expected_results[$];

    // First valid way in the set whose line address matches, else WAYS.
    function automatic int match_way(int base, logic [ADDR_W-1:0] addr);
        for (int w = 0; w < WAYS; w++)
            if (line_valid[base + w] &&
                line_addr[base + w][ADDR_W-1:LINE_OFFSET_BITS] ==
                addr[ADDR_W-1:LINE_OFFSET_BITS])
                return w;
        return WAYS;
    endfunction

    // Applies one request word to the model store and returns its result.
    function automatic result_t access_line(logic [127:0] word);
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        kind;
        logic              own_pf;
        logic [DATA_W-1:0] fdata;
        logic [WAY_W-1:0]  victim;
        logic              wb_ready;
        int                base;
        int                w;
        int                i;
        result_t           r;
        cmd      = word[1:0];
        addr     = word[49:2];
        kind     = word[52:50];
        own_pf   = word[53];
        fdata    = word[117:54];
        victim   = word[121:118];
        wb_ready = word[122];
        base = (SET_BITS == 0) ? 0 :
               int'((addr >> LINE_OFFSET_BITS) & ((1 << SET_BITS) - 1)) * WAYS;
        r = '{default: '0};
        r.way_index = NO_WAY;
        if (cmd == CMD_LOOKUP) begin
            w = match_way(base, addr);
            if (w < WAYS) begin
                i = base + w;
                r.hit             = 1'b1;
                r.way_index       = WAY_W'(w);
                r.pf_useful       = line_pf[i] && !own_pf;
                r.read_data       = line_payload[i];
                if (kind == KIND_WRITE)
                    line_dirty[i] = 1'b1;
                if (r.pf_useful)
                    line_pf[i] = 1'b0;
            end
        end else if (cmd == CMD_FILL) begin
            w = WAYS;
            for (int k = WAYS - 1; k >= 0; k--)
                if (!line_valid[base + k])
                    w = k;
            if (w == WAYS && victim < WAYS)
                w = int'(victim);
            if (w == WAYS) begin
                // Bypass: accepted, nothing stored.
                r.accepted = 1'b1;
            end else begin
                i = base + w;
                r.way_index = WAY_W'(w);
                if (line_valid[i] && line_dirty[i] && !wb_ready)
                    return r;
                if (line_valid[i] && line_dirty[i]) begin
                    r.writeback_valid   = 1'b1;
                    r.writeback_address = line_addr[i];
                    r.writeback_data    = line_payload[i];
                end
                r.accepted      = 1'b1;
                line_valid[i]   = 1'b1;
                line_dirty[i]   = (kind == KIND_WRITE);
                line_pf[i]      = own_pf;
                line_addr[i]    = addr;
                line_payload[i] = fdata;
            end
        end else if (cmd == CMD_INVALIDATE) begin
            w = match_way(base, addr);
            if (w < WAYS) begin
                line_valid[base + w] = 1'b0;
                r.hit       = 1'b1;
                r.way_index = WAY_W'(w);
            end
        end
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // Compare leaving result words first, then predict newly accepted requests.
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t act_r;
        result_t new_r;
        if (!rst_n) begin
            for (int i = 0; i < LINES; i++)
                line_valid[i] = 1'b0;
            expected_results.delete();
            error_count     <= 0;
            hit_count       <= 0;
            writeback_count <= 0;
            refused_count   <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_r.hit               = m_axis_tdata[0];
                act_r.way_index         = m_axis_tdata[4:1];
                act_r.pf_useful         = m_axis_tdata[5];
                act_r.read_data         = m_axis_tdata[69:6];
                act_r.accepted          = m_axis_tdata[70];
                act_r.writeback_valid   = m_axis_tdata[71];
                act_r.writeback_address = m_axis_tdata[119:72];
                act_r.writeback_data    = m_axis_tdata[183:120];
                if (expected_results.size() == 0) begin
                    if (error_count < 10)
                        $display("ERROR: result word with no request pending: %h",
                                 m_axis_tdata);
                    error_count <= error_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.hit != act_r.hit || exp_r.way_index != act_r.way_index ||
                        exp_r.pf_useful != act_r.pf_useful ||
                        exp_r.read_data != act_r.read_data ||
                        exp_r.accepted != act_r.accepted ||
                        exp_r.writeback_valid != act_r.writeback_valid ||
                        exp_r.writeback_address != act_r.writeback_address ||
                        exp_r.writeback_data != act_r.writeback_data) begin
                        if (error_count < 10) begin
                            $display("ERROR: exp hit=%b way=%0d upf=%b rd=%h acc=%b wb=%b %h %h",
                                     exp_r.hit, exp_r.way_index, exp_r.pf_useful,
                                     exp_r.read_data, exp_r.accepted, exp_r.writeback_valid,
                                     exp_r.writeback_address, exp_r.writeback_data);
                            $display("       got hit=%b way=%0d upf=%b rd=%h acc=%b wb=%b %h %h",
                                     act_r.hit, act_r.way_index, act_r.pf_useful,
                                     act_r.read_data, act_r.accepted, act_r.writeback_valid,
                                     act_r.writeback_address, act_r.writeback_data);
                        end
                        error_count <= error_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                new_r = access_line(s_axis_tdata);
                expected_results.insert(expected_results.size(), new_r);
                if (new_r.hit)
                    hit_count <= hit_count + 1;
                if (new_r.writeback_valid)
                    writeback_count <= writeback_count + 1;
                if (s_axis_tdata[1:0] == CMD_FILL && !new_r.accepted)
                    refused_count <= refused_count + 1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_set_assoc_cache_tag_array_unit.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_array_unit
// Drives request words into the cache tag array: a directed opening that
// fills, hits, evicts, bypasses, refuses and invalidates, then random
// traffic focused on a few crowded sets, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_set_assoc_cache_tag_array_unit;
    import sacta_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_PF      = 3'd2;
    localparam int         RANDOM_WORDS = 930;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOT_SETS     = 6;
    localparam int         HOT_TAGS     = 12;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;

    int errors, pending, hits, writebacks, refusals;
    int cycles = 0;
    bit quiet_phase = 1'b0;

    logic [5:0]  hot_set[HOT_SETS];
    logic [35:0] hot_tag[HOT_TAGS];

    always #4 clk = ~clk;

    set_assoc_cache_tag_array_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    set_assoc_cache_tag_array_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .error_count(errors), .pending_count(pending), .hit_count(hits),
        .writeback_count(writebacks), .refused_count(refusals)
    );

    // Gap length: mostly short, now and then long.
    function automatic int gap_length();
        if (quiet_phase)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver side: alternating ready and stall runs.
    always @(posedge clk)
    begin
        int run;
        cycles <= cycles + 1;
        if (run > 0) begin
            run = run - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
            run = $urandom_range(0, 12);
        end else begin
            run = gap_length();
            if (run > 0)
                m_axis_tready <= 1'b0;
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT) begin
            $display("set_assoc_cache_tag_array_unit: mismatch");
            $finish;
        end
    end

    // Presents one request word and holds it until it is taken.
    task automatic send_word(input logic [1:0] cmd, input logic [47:0] addr,
                             input logic [2:0] kind, input logic own_pf,
                             input logic [63:0] fdata, input logic [3:0] victim,
                             input logic wb_ready);
        int gap;
        s_axis_tdata  <= {5'b0, wb_ready, victim, fdata, own_pf, kind, addr, cmd};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [47:0] line_in_set(logic [35:0] tag, logic [5:0] set_idx);
        return {tag, set_idx, 6'($urandom_range(0, 63))};
    endfunction

    initial
    begin
        logic [47:0] a;
        logic [1:0]  cmd;
        logic [2:0]  kind;
        int          pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Fill all eight ways of set 0 with dirty lines, the last one prefetched.
        for (int w = 0; w < 8; w++)
            send_word(CMD_FILL, {36'(w + 1), 6'd0, 6'd0}, KIND_WRITE, w == 7,
                      {$urandom, $urandom}, 4'd0, 1'b1);
        // Hits: plain, useful prefetch, then the same line again.
        send_word(CMD_LOOKUP, {36'd1, 6'd0, 6'h3f}, KIND_LOAD, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_LOOKUP, {36'd8, 6'd0, 6'd5}, KIND_PF, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_LOOKUP, {36'd8, 6'd0, 6'd5}, 3'd7, 1'b1, '0, 4'd0, 1'b0);
        // Full set: bypass by way 8 and way 15, refused and taken writebacks.
        send_word(CMD_FILL, {36'd20, 6'd0, 6'd0}, KIND_WRITE, 1'b0, '1, 4'd8, 1'b1);
        send_word(CMD_FILL, {36'd21, 6'd0, 6'd0}, KIND_LOAD, 1'b1, '1, 4'd15, 1'b0);
        send_word(CMD_FILL, {36'd22, 6'd0, 6'd0}, KIND_LOAD, 1'b0, '1, 4'd3, 1'b0);
        send_word(CMD_FILL, {36'd22, 6'd0, 6'd0}, 3'd5, 1'b0, '1, 4'd3, 1'b1);
        // Invalidate hit and miss, unknown command, extreme addresses.
        send_word(CMD_INVALIDATE, {36'd2, 6'd0, 6'd9}, KIND_LOAD, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_INVALIDATE, {36'd2, 6'd0, 6'd9}, KIND_LOAD, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_UNKNOWN, '1, 3'd7, 1'b1, '1, 4'd15, 1'b1);
        send_word(CMD_FILL, '1, KIND_WRITE, 1'b1, '1, 4'd0, 1'b1);
        send_word(CMD_LOOKUP, '1, 3'd6, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_LOOKUP, '0, KIND_LOAD, 1'b0, '0, 4'd0, 1'b0);
        send_word(CMD_INVALIDATE, '1, KIND_LOAD, 1'b0, '0, 4'd0, 1'b0);

        // Random traffic on a handful of crowded sets, with some noise.
        hot_set[0] = 6'd0;
        hot_set[1] = 6'd63;
        for (int i = 2; i < HOT_SETS; i++)
            hot_set[i] = 6'($urandom);
        for (int i = 0; i < HOT_TAGS; i++)
            hot_tag[i] = {$urandom, 4'($urandom)};
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet_phase = (n >= 400 && n < 500);
            if ($urandom_range(0, 19) == 0)
                a = {$urandom, 16'($urandom)};
            else
                a = line_in_set(hot_tag[$urandom_range(0, HOT_TAGS - 1)],
                                hot_set[$urandom_range(0, HOT_SETS - 1)]);
            pick = $urandom_range(0, 99);
            cmd = (pick < 50) ? CMD_LOOKUP : (pick < 85) ? CMD_FILL :
                  (pick < 97) ? CMD_INVALIDATE : CMD_UNKNOWN;
            kind = ($urandom_range(0, 2) == 0) ? KIND_WRITE : 3'($urandom);
            send_word(cmd, a, kind, 1'($urandom),
                      {$urandom, $urandom},
                      ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 7)),
                      $urandom_range(0, 4) != 0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests: %0d hits, %0d writebacks, %0d refused fills.",
                 RANDOM_WORDS + 22, hits, writebacks, refusals);
        if (errors == 0)
            $display("set_assoc_cache_tag_array_unit: match");
        else
            $display("set_assoc_cache_tag_array_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
